// ===== rtl/core/rspd_pkg.sv =====
package rspd_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [1:0] request_mask;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  field_id;
        logic [31:0] field_value;
        logic [1:0]  sent_request;
        logic        last;
    } out_item_t;

    localparam logic [5:0] NUM_FIELDS = 6'd33;
    localparam logic [31:0] BOUND_360 = 32'h43B40000;
    localparam logic [31:0] BOUND_180 = 32'h43340000;
    localparam logic [7:0] HDR_IMAGE = 8'h01;
    localparam logic [7:0] HDR_SENSOR = 8'h02;
    localparam logic [7:0] HDR_COMMAND = 8'h03;

    // Datapath operation codes issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_FIELD = 3'd1,
        OP_CMD   = 3'd2
    } dp_op_t;

    typedef struct packed {
        logic       store_wr;
        logic [7:0] store_addr;
        logic [7:0] store_data;
        logic       light_clear;
        logic       light_step;
        logic [2:0] light_idx;
        logic       light_commit;
        logic       issue;
        dp_op_t     op;
        logic [5:0] field_id;
        logic [1:0] req;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

    // Byte offset of the low byte for each field.
    function automatic logic [7:0] field_offset(input logic [5:0] id);
        logic [7:0] r;
        begin
            r = 8'd0;
            case (id)
                6'd0: r = 8'd6;
                6'd1: r = 8'd10;
                6'd2: r = 8'd14;
                6'd3, 6'd4, 6'd5: r = 8'(8'd18 + 8'(2 * (id - 6'd3)));
                6'd6, 6'd7, 6'd8: r = 8'(8'd24 + 8'(4 * (id - 6'd6)));
                6'd18, 6'd19: r = 8'd69;
                6'd32: r = 8'd102;
                default: begin
                    if (id >= 6'd9 && id <= 6'd16) r = 8'(8'd37 + 8'(2 * (id - 6'd9)));
                    else if (id >= 6'd20 && id <= 6'd26)
                        r = 8'(8'd71 + 8'(2 * (id - 6'd20)));
                    else if (id >= 6'd27 && id <= 6'd31) r = 8'(8'd85 + 8'(id - 6'd27));
                end
            endcase
            field_offset = r;
        end
    endfunction

endpackage

// ===== rtl/core/robot_sensor_packet_deframer.sv =====
// Robot sensor packet deframer.
// The s_ channel takes one transaction per link byte or request-mask update;
// the m_ channel delivers decoded sensor fields and command records, with
// last set on the final record caused by an input transaction.
// A link byte with no result leaves s_ready high, and a request mask is
// stored without dropping s_ready.
// The closing byte of a sensor packet starts a light-average pass (one
// stored 16-bit pair per cycle) and then 33 field records, each issued only
// once the one before it has left the output register, through the registered
// store read, the issue stage and the output register, with an optional
// command record after them; s_ready returns once the last record is taken.
// The output register holds a record until m_ready; while a record waits
// the controller holds s_ready low and issues nothing new.
// Reset clears the parser to idle, drops any pending command and restores
// the sensors-only request; the packet store is not cleared.
module robot_sensor_packet_deframer #(
    parameter int SENSOR_PACKET_BYTES = 104,
    parameter int IMAGE_PACKET_BYTES = 38400
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rspd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rspd_pkg::out_item_t m_item
);

    rspd_pkg::dp_cmd_t    cmd;
    rspd_pkg::dp_status_t status;

    rspd_ctrl #(
        .SENSOR_PACKET_BYTES(SENSOR_PACKET_BYTES),
        .IMAGE_PACKET_BYTES(IMAGE_PACKET_BYTES)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .status(status), .cmd(cmd)
    );

    rspd_datapath #(
        .SENSOR_PACKET_BYTES(SENSOR_PACKET_BYTES)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule

// ===== rtl/core/rspd_datapath.sv =====
module rspd_datapath #(
    parameter int SENSOR_PACKET_BYTES = 104
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rspd_pkg::dp_cmd_t   cmd,
    output rspd_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output rspd_pkg::out_item_t m_item
);

    localparam int STORE_WORDS = (SENSOR_PACKET_BYTES + 1) / 2;
    localparam int WA = $clog2(STORE_WORDS);

    // The store is split into even and odd byte lanes so that any 16-bit or
    // 32-bit field is read at two word addresses.
    logic [7:0]  store_lo_mem [STORE_WORDS];
    logic [7:0]  store_hi_mem [STORE_WORDS];
    logic [7:0]  lo0_reg, hi0_reg, lo1_reg, hi1_reg;
    logic        odd_reg;
    logic [7:0]  rd0, rd1, rd2, rd3;
    logic [6:0]  w0, w1, wr_word;
    logic        s1_valid_reg;
    rspd_pkg::dp_op_t s1_op_reg;
    logic [5:0]  s1_id_reg;
    logic [1:0]  s1_req_reg;
    logic        s1_last_reg;
    logic        ov_reg;
    rspd_pkg::out_item_t out_reg;
    logic signed [19:0] lsum_reg;
    logic [11:0] light_reg;
    logic [7:0]  base;
    logic [7:0]  a0;
    logic [7:0]  lo_addr;
    logic signed [19:0] lsum_next;
    logic signed [19:0] lsum_div;
    logic [11:0] light_next;
    logic [31:0] u32v, value;
    logic [15:0] u16v;
    logic signed [16:0] s16v;
    logic [31:0] mm_div;

    assign base = rspd_pkg::field_offset(cmd.field_id);
    assign lo_addr = 8'(8'd53 + {4'd0, cmd.light_idx, 1'b0});
    assign a0 = cmd.light_step ? lo_addr : base;
    assign w0 = a0[7:1];
    assign w1 = 7'(w0 + 7'd1);
    assign wr_word = cmd.store_addr[7:1];

    always_ff @(posedge aclk) begin
        if (cmd.store_wr && 32'(cmd.store_addr) < SENSOR_PACKET_BYTES) begin
            if (cmd.store_addr[0]) begin
                store_hi_mem[wr_word[WA-1:0]] <= cmd.store_data;
            end else begin
                store_lo_mem[wr_word[WA-1:0]] <= cmd.store_data;
            end
        end
        lo0_reg <= (32'(w0) < STORE_WORDS) ? store_lo_mem[w0[WA-1:0]] : 8'd0;
        hi0_reg <= (32'(w0) < STORE_WORDS) ? store_hi_mem[w0[WA-1:0]] : 8'd0;
        lo1_reg <= (32'(w1) < STORE_WORDS) ? store_lo_mem[w1[WA-1:0]] : 8'd0;
        hi1_reg <= (32'(w1) < STORE_WORDS) ? store_hi_mem[w1[WA-1:0]] : 8'd0;
        odd_reg <= a0[0];
    end

    assign rd0 = odd_reg ? hi0_reg : lo0_reg;
    assign rd1 = odd_reg ? lo1_reg : hi0_reg;
    assign rd2 = lo1_reg;
    assign rd3 = hi1_reg;

    // Light accumulator: one 16-bit pair per cycle, read data registered.
    logic        lacc_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lacc_reg <= 1'b0;
        end else begin
            lacc_reg <= cmd.light_step;
        end
    end

    assign s16v = 17'(signed'(rd0)) + 17'(signed'(rd1)) * 17'sd256;
    assign lsum_next = lacc_reg ? 20'(lsum_reg + 20'(s16v)) : lsum_reg;
    assign lsum_div = (lsum_reg < 0) ? 20'((lsum_reg + 20'sd7) >>> 3) : (lsum_reg >>> 3);
    assign light_next = (lsum_div < 0) ? 12'd0 :
                        (lsum_div > 20'sd4000) ? 12'd4000 : lsum_div[11:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsum_reg <= '0;
            light_reg <= '0;
        end else if (cmd.light_clear) begin
            lsum_reg <= 20'(light_reg);
        end else if (cmd.light_commit) begin
            light_reg <= light_next;
        end else begin
            lsum_reg <= lsum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (cmd.issue) begin
            s1_valid_reg <= 1'b1;
        end else if (!ov_reg || m_ready) begin
            s1_valid_reg <= 1'b0;
        end
        if (cmd.issue) begin
            s1_op_reg <= cmd.op;
            s1_id_reg <= cmd.field_id;
            s1_req_reg <= cmd.req;
            s1_last_reg <= cmd.last;
        end
    end

    assign u32v = {rd3, rd2, rd1, rd0};
    assign u16v = {rd1, rd0};
    assign mm_div = (32'(u16v) * 32'd52429) >> 19;

    function automatic logic [31:0] clamp_ang(input logic [31:0] b, input logic [31:0] bd);
        if (b[30:0] > 31'h7F800000) clamp_ang = b;
        else if (b[31]) clamp_ang = (b[30:0] == 31'd0) ? b : 32'd0;
        else clamp_ang = (b > bd) ? bd : b;
    endfunction

    always_comb begin
        value = 32'd0;
        case (s1_id_reg)
            6'd0, 6'd6, 6'd7, 6'd8: value = u32v;
            6'd1: value = clamp_ang(u32v, rspd_pkg::BOUND_360);
            6'd2: value = clamp_ang(u32v, rspd_pkg::BOUND_180);
            6'd3, 6'd4, 6'd5: value = 32'(signed'(s16v));
            6'd17: value = 32'(light_reg);
            6'd18: value = 32'(u16v);
            6'd19: value = mm_div;
            6'd24, 6'd25, 6'd26: value = 32'(u16v);
            6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32: value = 32'(signed'(rd0));
            default: begin
                if (s1_id_reg >= 6'd9 && s1_id_reg <= 6'd16)
                    value = s16v[16] ? 32'd0 : (s16v > 17'sd2000) ? 32'd2000 : 32'(s16v);
                else if (s1_id_reg >= 6'd20 && s1_id_reg <= 6'd23)
                    value = (u16v > 16'd1500) ? 32'd1500 : 32'(u16v);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (s1_valid_reg && (!ov_reg || m_ready)) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
        if (s1_valid_reg && (!ov_reg || m_ready)) begin
            out_reg.kind <= (s1_op_reg == rspd_pkg::OP_CMD);
            out_reg.field_id <= (s1_op_reg == rspd_pkg::OP_CMD) ? 6'd0 : s1_id_reg;
            out_reg.field_value <= (s1_op_reg == rspd_pkg::OP_CMD) ? 32'd0 : value;
            out_reg.sent_request <= (s1_op_reg == rspd_pkg::OP_CMD) ? s1_req_reg : 2'd0;
            out_reg.last <= s1_last_reg;
        end
    end

    assign status.busy = s1_valid_reg || ov_reg;
    assign m_valid = ov_reg;
    assign m_item = out_reg;

endmodule

// ===== rtl/core/rspd_ctrl.sv =====
module rspd_ctrl #(
    parameter int SENSOR_PACKET_BYTES = 104,
    parameter int IMAGE_PACKET_BYTES = 38400
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rspd_pkg::in_item_t   s_item,
    input  rspd_pkg::dp_status_t status,
    output rspd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_IMAGE  = 6'b000010,
        ST_SENSOR = 6'b000100,
        ST_LIGHT  = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_DRAIN  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic [5:0]  fid_reg, fid_next;
    logic        pend_reg, pend_next;
    logic [1:0]  preq_reg, preq_next;
    logic [1:0]  areq_reg, areq_next;
    logic        acc;
    logic        cmd_emit;

    assign s_ready = (state_reg == ST_IDLE || state_reg == ST_IMAGE ||
                      state_reg == ST_SENSOR) && !status.busy;
    assign acc = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        fid_next = fid_reg;
        pend_next = pend_reg;
        preq_next = preq_reg;
        areq_next = areq_reg;
        cmd = '0;
        cmd.op = rspd_pkg::OP_NONE;
        cmd_emit = 1'b0;
        cmd.store_addr = count_reg[7:0];
        cmd.store_data = s_item.rx_byte;
        cmd.field_id = fid_reg;
        cmd.light_idx = fid_reg[2:0];
        unique case (state_reg)
            ST_IDLE, ST_IMAGE, ST_SENSOR: begin
                if (acc && s_item.opcode) begin
                    pend_next = 1'b1;
                    preq_next = s_item.request_mask;
                end else if (acc) begin
                    unique case (state_reg)
                        ST_IMAGE: begin
                            count_next = 16'(count_reg + 16'd1);
                            if (32'(count_next) >= IMAGE_PACKET_BYTES) begin
                                count_next = '0;
                                state_next = ST_IDLE;
                                cmd_emit = !areq_reg[1] && pend_reg;
                            end
                        end
                        ST_SENSOR: begin
                            cmd.store_wr = 1'b1;
                            count_next = 16'(count_reg + 16'd1);
                            if (32'(count_next) >= SENSOR_PACKET_BYTES) begin
                                count_next = '0;
                                fid_next = '0;
                                state_next = ST_LIGHT;
                            end
                        end
                        default: begin
                            count_next = '0;
                            if (s_item.rx_byte == rspd_pkg::HDR_IMAGE) state_next = ST_IMAGE;
                            else if (s_item.rx_byte == rspd_pkg::HDR_SENSOR)
                                state_next = ST_SENSOR;
                            else if (s_item.rx_byte == rspd_pkg::HDR_COMMAND)
                                cmd_emit = pend_reg;
                        end
                    endcase
                end
            end
            ST_LIGHT: begin
                // fid_reg counts 0..7 pair reads, then 8..10 settle and commit.
                cmd.light_clear = (fid_reg == 6'd0);
                cmd.light_step = (fid_reg < 6'd8);
                cmd.light_commit = (fid_reg == 6'd10);
                fid_next = 6'(fid_reg + 6'd1);
                if (fid_reg == 6'd10) begin
                    fid_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.busy) begin
                    cmd.issue = 1'b1;
                    cmd.op = rspd_pkg::OP_FIELD;
                    cmd.last = (fid_reg == rspd_pkg::NUM_FIELDS - 6'd1) && !pend_reg;
                    fid_next = 6'(fid_reg + 6'd1);
                    if (fid_reg == rspd_pkg::NUM_FIELDS - 6'd1) begin
                        fid_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    cmd_emit = pend_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd_emit) begin
            cmd.issue = 1'b1;
            cmd.op = rspd_pkg::OP_CMD;
            cmd.req = preq_reg;
            cmd.last = 1'b1;
            pend_next = 1'b0;
            areq_next = preq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            fid_reg <= '0;
            pend_reg <= 1'b0;
            preq_reg <= 2'd2;
            areq_reg <= 2'd2;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            fid_reg <= fid_next;
            pend_reg <= pend_next;
            preq_reg <= preq_next;
            areq_reg <= areq_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> !status.busy) else $error("accept while busy");
    a_emit_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !s_ready) else $error("input open during emit");
    a_cmd_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_emit |=> !pend_reg || $past(acc && s_item.opcode)) else $error("pending kept");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int PKT_BYTES = 104;
    localparam int IMG_BYTES = 38400;
    localparam logic OPC_BYTE = 1'b0;
    localparam logic OPC_REQUEST = 1'b1;
    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_CMD = 1'b1;
    localparam logic [1:0] REQ_IMAGE = 2'b01;
    localparam logic [1:0] REQ_SENSOR = 2'b10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    rspd_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rspd_pkg::out_item_t m_item;

    rspd_pkg::in_item_t stim_q[$];
    rspd_pkg::out_item_t record_q[$];
    int unsigned cycle_cnt = 0;
    int unsigned error_cnt = 0;
    int unsigned record_cnt = 0;
    int unsigned sensor_pkt_cnt = 0;
    int unsigned image_pkt_cnt = 0;

    logic [1:0] parser_mode = 2'd0;
    int unsigned rx_count = 0;
    logic [7:0] frame_mem [PKT_BYTES];
    logic cmd_waiting = 1'b0;
    logic [1:0] next_req = REQ_SENSOR;
    logic [1:0] cur_req = REQ_SENSOR;
    int light_avg = 0;

    robot_sensor_packet_deframer u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] u16(int i);
        return {16'd0, frame_mem[i + 1], frame_mem[i]};
    endfunction

    function automatic logic [31:0] u32(int i);
        return {frame_mem[i + 3], frame_mem[i + 2], frame_mem[i + 1], frame_mem[i]};
    endfunction

    function automatic int s8(int i);
        return int'($signed(frame_mem[i]));
    endfunction

    function automatic int s16sum(int i);
        return s8(i) + s8(i + 1) * 256;
    endfunction

    function automatic logic [31:0] clamp_angle(logic [31:0] bits, logic [31:0] bound);
        if (bits[30:0] > 31'h7F800000) return bits;
        if (bits[31]) return (bits[30:0] == 31'd0) ? bits : 32'd0;
        return (bits > bound) ? bound : bits;
    endfunction

    function automatic logic [31:0] clamp_int(int v, int lo, int hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    task automatic put_record(ref rspd_pkg::out_item_t recs[$], input logic kind, input int id,
                              input logic [31:0] value, input logic [1:0] req);
        rspd_pkg::out_item_t r;
        r.kind = kind;
        r.field_id = 6'(id);
        r.field_value = value;
        r.sent_request = req;
        r.last = 1'b0;
        recs.push_back(r);
    endtask

    task automatic release_cmd(ref rspd_pkg::out_item_t recs[$]);
        if (cmd_waiting) begin
            cmd_waiting = 1'b0;
            cur_req = next_req;
            put_record(recs, KIND_CMD, 0, 32'd0, cur_req);
        end
    endtask

    task automatic decode_fields(ref rspd_pkg::out_item_t recs[$]);
        int id;
        int sum;
        logic [31:0] v;
        id = 0;
        put_record(recs, KIND_FIELD, id++, u32(6), 2'd0);
        put_record(recs, KIND_FIELD, id++, clamp_angle(u32(10), rspd_pkg::BOUND_360), 2'd0);
        put_record(recs, KIND_FIELD, id++, clamp_angle(u32(14), rspd_pkg::BOUND_180), 2'd0);
        for (int i = 0; i < 3; i++) put_record(recs, KIND_FIELD, id++, s16sum(18 + 2 * i), 2'd0);
        for (int i = 0; i < 3; i++) put_record(recs, KIND_FIELD, id++, u32(24 + 4 * i), 2'd0);
        for (int i = 0; i < 8; i++)
            put_record(recs, KIND_FIELD, id++, clamp_int(s16sum(37 + 2 * i), 0, 2000), 2'd0);
        sum = light_avg;
        for (int i = 0; i < 8; i++) sum += s16sum(53 + 2 * i);
        sum = sum / 8;
        light_avg = clamp_int(sum, 0, 4000);
        put_record(recs, KIND_FIELD, id++, light_avg, 2'd0);
        put_record(recs, KIND_FIELD, id++, u16(69), 2'd0);
        put_record(recs, KIND_FIELD, id++, u16(69) / 10, 2'd0);
        for (int i = 0; i < 4; i++) begin
            v = u16(71 + 2 * i);
            put_record(recs, KIND_FIELD, id++, (v > 1500) ? 32'd1500 : v, 2'd0);
        end
        put_record(recs, KIND_FIELD, id++, u16(79), 2'd0);
        put_record(recs, KIND_FIELD, id++, u16(81), 2'd0);
        put_record(recs, KIND_FIELD, id++, u16(83), 2'd0);
        for (int i = 85; i <= 89; i++) put_record(recs, KIND_FIELD, id++, s8(i), 2'd0);
        put_record(recs, KIND_FIELD, id++, s8(102), 2'd0);
    endtask

    task automatic deframe_predict(rspd_pkg::in_item_t it);
        rspd_pkg::out_item_t recs[$];
        if (it.opcode == OPC_REQUEST) begin
            next_req = it.request_mask;
            cmd_waiting = 1'b1;
            return;
        end
        case (parser_mode)
            2'd1: begin
                rx_count++;
                if (rx_count >= IMG_BYTES) begin
                    rx_count = 0;
                    parser_mode = 2'd0;
                    image_pkt_cnt++;
                    if (!cur_req[1]) release_cmd(recs);
                end
            end
            2'd2: begin
                frame_mem[rx_count] = it.rx_byte;
                rx_count++;
                if (rx_count >= PKT_BYTES) begin
                    rx_count = 0;
                    parser_mode = 2'd0;
                    sensor_pkt_cnt++;
                    decode_fields(recs);
                    release_cmd(recs);
                end
            end
            default: begin
                parser_mode = 2'd0;
                if (it.rx_byte == rspd_pkg::HDR_IMAGE) parser_mode = 2'd1;
                else if (it.rx_byte == rspd_pkg::HDR_SENSOR) parser_mode = 2'd2;
                else if (it.rx_byte == rspd_pkg::HDR_COMMAND) release_cmd(recs);
                rx_count = 0;
            end
        endcase
        if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
        foreach (recs[i]) record_q.push_back(recs[i]);
    endtask

    function automatic logic throttle();
        return !(cycle_cnt >= 400 && cycle_cnt < 1000) && $urandom_range(99) < 25;
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item <= '0;
        end else begin
            if (s_valid && s_ready) deframe_predict(s_item);
            if (!s_valid || s_ready) begin
                if (stim_q.size() > 0 && !throttle()) begin
                    s_item <= stim_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !throttle();
            if (m_valid && m_ready) begin
                if (record_q.size() == 0) begin
                    $error("unexpected record kind=%0d id=%0d value=%h", m_item.kind,
                           m_item.field_id, m_item.field_value);
                    error_cnt++;
                end else begin
                    rspd_pkg::out_item_t e;
                    e = record_q.pop_front();
                    record_cnt++;
                    if (m_item.kind !== e.kind) begin
                        $error("kind: expected %0d, actual %0d", e.kind, m_item.kind);
                        error_cnt++;
                    end
                    if (m_item.field_id !== e.field_id) begin
                        $error("field_id: expected %0d, actual %0d", e.field_id,
                               m_item.field_id);
                        error_cnt++;
                    end
                    if (m_item.field_value !== e.field_value) begin
                        $error("field_value: expected %h, actual %h", e.field_value,
                               m_item.field_value);
                        error_cnt++;
                    end
                    if (m_item.sent_request !== e.sent_request) begin
                        $error("sent_request: expected %0d, actual %0d", e.sent_request,
                               m_item.sent_request);
                        error_cnt++;
                    end
                    if (m_item.last !== e.last) begin
                        $error("last: expected %0d, actual %0d", e.last, m_item.last);
                        error_cnt++;
                    end
                end
            end
        end
    end

    task automatic add_byte(logic [7:0] b);
        rspd_pkg::in_item_t it;
        it.opcode = OPC_BYTE;
        it.rx_byte = b;
        it.request_mask = 2'($urandom);
        stim_q.push_back(it);
    endtask

    task automatic add_request(logic [1:0] m);
        rspd_pkg::in_item_t it;
        it.opcode = OPC_REQUEST;
        it.rx_byte = 8'($urandom);
        it.request_mask = m;
        stim_q.push_back(it);
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(9))
            0: return 32'h7FC00001;
            1: return 32'h80000000;
            2: return 32'h7F800000;
            3: return 32'hFF800000;
            4: return 32'h43B40001;
            5: return 32'h00000001;
            6: return 32'hBF800000;
            7: return 32'h43340000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_sensor_packet(int fill_mode);
        logic [7:0] body [PKT_BYTES];
        logic [31:0] f;
        for (int i = 0; i < PKT_BYTES; i++) begin
            case (fill_mode)
                0: body[i] = 8'h00;
                1: body[i] = 8'hFF;
                2: body[i] = 8'h7F;
                3: body[i] = 8'h80;
                default: body[i] = 8'($urandom);
            endcase
        end
        if (fill_mode >= 4) begin
            for (int k = 0; k < 3; k++) begin
                f = pick_float();
                {body[6 + 4 * k + 3], body[6 + 4 * k + 2], body[6 + 4 * k + 1],
                 body[6 + 4 * k]} = f;
            end
            if ($urandom_range(1)) {body[70], body[69]} = 16'($urandom_range(65535));
        end
        add_byte(rspd_pkg::HDR_SENSOR);
        for (int i = 0; i < PKT_BYTES; i++) begin
            if (fill_mode >= 4 && $urandom_range(60) == 0) add_request(2'($urandom));
            add_byte(body[i]);
        end
    endtask

    initial begin
        int wait_cnt;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        add_byte(rspd_pkg::HDR_COMMAND);
        add_byte(8'h00);
        add_byte(8'h04);
        add_byte(8'hFF);
        add_request(2'b11);
        add_byte(rspd_pkg::HDR_COMMAND);
        add_sensor_packet(1);
        add_request(2'b00);
        add_sensor_packet(3);
        add_request(REQ_IMAGE);
        add_byte(rspd_pkg::HDR_COMMAND);
        add_request(REQ_SENSOR);

        while (stim_q.size() < 370) begin
            if (stim_q.size() < 260) begin
                add_sensor_packet(4 + $urandom_range(3));
            end else begin
                case ($urandom_range(2))
                    0: add_request(2'($urandom));
                    1: add_byte(rspd_pkg::HDR_COMMAND);
                    default: add_byte(8'($urandom));
                endcase
            end
        end
        add_byte(rspd_pkg::HDR_IMAGE);
        for (int i = 0; i < 8; i++) add_byte(8'($urandom));

        while (stim_q.size() > 0 || s_valid) @(posedge aclk);
        wait_cnt = 0;
        while (record_q.size() > 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (200) @(posedge aclk);
        $display("Covered %0d sensor packets and %0d image packets, %0d records checked.",
                 sensor_pkt_cnt, image_pkt_cnt, record_cnt);
        if (error_cnt == 0 && record_q.size() == 0) begin
            $display("robot_sensor_packet_deframer: match");
        end else begin
            $display("robot_sensor_packet_deframer: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("robot_sensor_packet_deframer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rspd_pkg.sv
rtl/core/rspd_datapath.sv
rtl/core/rspd_ctrl.sv
rtl/core/robot_sensor_packet_deframer.sv
dv/tb.sv
